@@ rtl/hpq_pkg.sv @@
// Shared types for the binary heap priority queue.
// Result status codes and the controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package hpq_pkg;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_START,
		OP_UP,
		OP_LAST,
		OP_DOWN,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic start_up;
		logic start_last;
		logic up_more;
		logic dn_more;
	} sts_t;

endpackage

@@ rtl/hpq_ctrl.sv @@
// Controller state machine for the heap: sequences accept, sift-up, sift-down
// and result beats. Depends on hpq_pkg for the command and status bundles.
`timescale 1ns / 1ps

module hpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  hpq_pkg::sts_t sts,
	output hpq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_UP,
		S_LAST,
		S_DOWN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd.op = in_valid ? hpq_pkg::OP_ACCEPT : hpq_pkg::OP_NOP;
			S_START:  cmd.op = hpq_pkg::OP_START;
			S_UP:     cmd.op = hpq_pkg::OP_UP;
			S_LAST:   cmd.op = hpq_pkg::OP_LAST;
			S_DOWN:   cmd.op = hpq_pkg::OP_DOWN;
			S_FINISH: cmd.op = slot_free ? hpq_pkg::OP_RESULT : hpq_pkg::OP_NOP;
			default:  cmd.op = hpq_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (sts.start_up) begin
						state_q <= S_UP;
					end else if (sts.start_last) begin
						state_q <= S_LAST;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_UP: begin
					if (!sts.up_more) begin
						state_q <= S_FINISH;
					end
				end
				S_LAST: begin
					state_q <= S_DOWN;
				end
				S_DOWN: begin
					if (!sts.dn_more) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/hpq_datapath.sv @@
// Heap datapath: key memory (one write, two registered reads), moving key,
// hole position, fill count, mode register and result register.
// Depends on hpq_pkg; driven by hpq_ctrl commands.
`timescale 1ns / 1ps

module hpq_datapath #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          heap_mode,
	input  logic          req_type,
	input  logic [31:0]   key_in,
	input  hpq_pkg::cmd_t cmd,
	output hpq_pkg::sts_t sts,
	output logic [31:0]   head_key,
	output logic [6:0]    entry_count,
	output logic [1:0]    status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = CW + 1;

	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_a_q, rd_b_q;
	logic [KEY_WIDTH-1:0] cur_q, root_q, head_q;
	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        count_q, cnt_out_q;
	logic                 mode_q, is_rm_q;
	hpq_pkg::status_t     res_q, stat_out_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr, ra_addr, rb_addr;
	logic [KEY_WIDTH-1:0] wr_data, key_m, pick_key;
	logic [63:0]          key_wide, head_wide, cnt_wide;
	logic [AW-1:0]        par, gpar, cnt_pos, start_par;
	logic [CW-1:0]        cnt_m1;
	logic [IW-1:0]        left, right, pick_idx, pick_l, pick_r;
	logic                 has_l, has_r, take_r, descend, climb, full, empty;

	function automatic logic ranks_above(input logic mode, input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b);
		return mode ? (a > b) : (a < b);
	endfunction

	assign key_wide = 64'(key_in);
	assign key_m    = key_wide[KEY_WIDTH-1:0];

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign cnt_pos   = count_q[AW-1:0];
	assign cnt_m1    = count_q - 1'b1;
	assign start_par = (cnt_pos - 1'b1) >> 1;
	assign par       = (pos_q - 1'b1) >> 1;
	assign gpar      = (par - 1'b1) >> 1;
	assign climb     = ranks_above(mode_q, cur_q, rd_a_q);

	assign left     = (IW'(pos_q) << 1) + IW'(1);
	assign right    = left + IW'(1);
	assign has_l    = left < IW'(count_q);
	assign has_r    = right < IW'(count_q);
	assign take_r   = has_r && !ranks_above(mode_q, rd_a_q, rd_b_q);
	assign pick_idx = take_r ? right : left;
	assign pick_key = take_r ? rd_b_q : rd_a_q;
	assign descend  = has_l && ranks_above(mode_q, pick_key, cur_q);
	assign pick_l   = (pick_idx << 1) + IW'(1);
	assign pick_r   = pick_l + IW'(1);

	assign sts.start_up   = !is_rm_q && !full && !empty;
	assign sts.start_last = is_rm_q && (count_q > CW'(1));
	assign sts.up_more    = (pos_q != '0) && climb;
	assign sts.dn_more    = descend;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		ra_addr = '0;
		rb_addr = '0;
		case (cmd.op)
			hpq_pkg::OP_START: begin
				if (!is_rm_q) begin
					wr_en   = empty;
					wr_addr = '0;
					ra_addr = start_par;
				end else begin
					ra_addr = cnt_m1[AW-1:0];
				end
			end
			hpq_pkg::OP_UP: begin
				wr_en   = 1'b1;
				wr_data = sts.up_more ? rd_a_q : cur_q;
				ra_addr = gpar;
			end
			hpq_pkg::OP_LAST: begin
				ra_addr = AW'(1);
				rb_addr = AW'(2);
			end
			hpq_pkg::OP_DOWN: begin
				wr_en   = 1'b1;
				wr_data = descend ? pick_key : cur_q;
				ra_addr = pick_l[AW-1:0];
				rb_addr = pick_r[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[ra_addr];
		rd_b_q <= mem[rb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			if (cfg_wr_en && empty) begin
				mode_q <= heap_mode;
			end
			if (cmd.op == hpq_pkg::OP_START) begin
				if (!is_rm_q && !full) begin
					count_q <= count_q + 1'b1;
				end else if (is_rm_q && !empty) begin
					count_q <= cnt_m1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hpq_pkg::OP_ACCEPT: begin
				is_rm_q <= req_type;
				cur_q   <= key_m;
			end
			hpq_pkg::OP_START: begin
				pos_q <= cnt_pos;
				if (!is_rm_q) begin
					res_q <= full ? hpq_pkg::STAT_FULL : hpq_pkg::STAT_DONE;
					if (empty) begin
						root_q <= cur_q;
					end
				end else begin
					res_q <= empty ? hpq_pkg::STAT_EMPTY : hpq_pkg::STAT_DONE;
				end
			end
			hpq_pkg::OP_UP: begin
				if (pos_q == '0) begin
					root_q <= cur_q;
				end else if (climb) begin
					pos_q <= par;
				end
			end
			hpq_pkg::OP_LAST: begin
				cur_q <= rd_a_q;
				pos_q <= '0;
			end
			hpq_pkg::OP_DOWN: begin
				if (pos_q == '0) begin
					root_q <= wr_data;
				end
				if (descend) begin
					pos_q <= pick_idx[AW-1:0];
				end
			end
			hpq_pkg::OP_RESULT: begin
				head_q     <= empty ? '0 : root_q;
				cnt_out_q  <= count_q;
				stat_out_q <= res_q;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign head_wide   = 64'(head_q);
	assign cnt_wide    = 64'(cnt_out_q);
	assign head_key    = head_wide[31:0];
	assign entry_count = cnt_wide[6:0];
	assign status      = stat_out_q;

endmodule

@@ rtl/binary_heap_priority_queue.sv @@
// Top level of the binary heap priority queue: controller plus datapath.
// Depends on hpq_pkg, hpq_ctrl and hpq_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): req_type 0 inserts key_in, 1 removes
//   the head entry. Output channel (out_valid/out_ready): one beat per
//   request with head_key (root after the operation, zero when empty),
//   entry_count and status (done, insert refused full, remove refused empty).
//   heap_mode is written by cfg_wr_en (0 min-heap, 1 max-heap) and takes
//   effect only while the heap is empty.
// Sequencing: one request is in work at a time.
//   An insert climbs one level per sift-up step; a remove takes the last
//   entry to the root and descends one level per sift-down step; an insert
//   into an empty heap, a refused request or the removal of the last entry
//   goes from the start step to the result. Each sift step makes one write
//   through the single write port of the key memory. The next request is
//   accepted the cycle after the result is registered.
// Reset: the heap is empty and the mode is min-heap; no clearing pass.
// Stall: a finished result waits in the output register; the next request
//   is accepted and processed, and holds in its final step until the
//   waiting beat is taken.
`timescale 1ns / 1ps

module binary_heap_priority_queue #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        heap_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] key_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] head_key,
	output logic [6:0]  entry_count,
	output logic [1:0]  status
);

	hpq_pkg::cmd_t cmd;
	hpq_pkg::sts_t sts;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpq_datapath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.heap_mode   (heap_mode),
		.req_type    (req_type),
		.key_in      (key_in),
		.cmd         (cmd),
		.sts         (sts),
		.head_key    (head_key),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule

@@ rtl/hpq_checker.sv @@
// Port-level checker for binary_heap_priority_queue, attached by bind.
// Depends on hpq_pkg for status codes.
`timescale 1ns / 1ps

module hpq_checker #(
	parameter int DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] head_key,
	input logic [6:0]  entry_count,
	input logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_key) && $stable(status))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == 7'd0 |-> head_key == 32'd0)
		else $error("empty heap reports a nonzero head");

	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hpq_pkg::STAT_EMPTY |-> entry_count == 7'd0)
		else $error("remove refused while entries held");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hpq_pkg::STAT_FULL |-> entry_count == 7'(DEPTH))
		else $error("insert refused while not full");

endmodule

bind binary_heap_priority_queue hpq_checker #(.DEPTH(DEPTH)) u_hpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.head_key    (head_key),
	.entry_count (entry_count),
	.status      (status)
);
